@@ src/lcslt_pkg.sv @@
package lcslt_pkg;

  // Meaning of the input tuser bit.
  localparam logic KIND_FIRST  = 1'b0;
  localparam logic KIND_SECOND = 1'b1;

  // Bit positions inside a cell's traceback entry.
  localparam int DIR_UP    = 0;
  localparam int DIR_MATCH = 1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_TB_RD,
    ST_TB_DEC,
    ST_OUT_RD,
    ST_OUT_SET,
    ST_OUT_WAIT
  } state_e;

endpackage

@@ src/lcslt_cell.sv @@
module lcslt_cell #(
  parameter int MAX_LEN = 64,
  parameter int AW      = 6,
  parameter int VW      = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_en_i,
  input  logic [7:0]    load_sym_i,
  input  logic          in_valid_i,
  input  logic          in_first_i,
  input  logic [7:0]    in_sym_i,
  input  logic [AW-1:0] in_row_i,
  input  logic [VW-1:0] in_up_i,
  input  logic [VW-1:0] in_diag_i,
  output logic          out_valid_o,
  output logic          out_first_o,
  output logic [7:0]    out_sym_o,
  output logic [AW-1:0] out_row_o,
  output logic [VW-1:0] out_up_o,
  output logic [VW-1:0] out_diag_o,
  output logic [VW-1:0] val_o,
  output logic [7:0]    byte_o,
  input  logic [AW-1:0] rd_addr_i,
  output logic [1:0]    dir_o
);

  logic [7:0]    byte_q;
  logic [VW-1:0] val_q;
  logic [VW-1:0] left;
  logic [VW-1:0] val_d;
  logic          match;
  logic          up_wins;
  logic          valid_q;
  logic          first_q;
  logic [7:0]    sym_q;
  logic [AW-1:0] row_q;
  logic [VW-1:0] up_q;
  logic [VW-1:0] diag_q;
  logic [1:0]    dir_mem [MAX_LEN];
  logic [1:0]    dir_q;

  // The entry to the left is this cell's result for the previous row,
  // or the zero border when this is the first row of a run.
  assign left    = in_first_i ? '0 : val_q;
  assign match   = (byte_q == in_sym_i);
  assign up_wins = (in_up_i >= left);
  assign val_d   = match ? VW'(in_diag_i + 1'b1) : (up_wins ? in_up_i : left);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      byte_q <= load_sym_i;
    end
    if (in_valid_i) begin
      val_q            <= val_d;
      dir_mem[in_row_i] <= {match, up_wins};
    end
    first_q <= in_first_i;
    sym_q   <= in_sym_i;
    row_q   <= in_row_i;
    up_q    <= val_d;
    diag_q  <= left;
    dir_q   <= dir_mem[rd_addr_i];
  end

  assign out_valid_o = valid_q;
  assign out_first_o = first_q;
  assign out_sym_o   = sym_q;
  assign out_row_o   = row_q;
  assign out_up_o    = up_q;
  assign out_diag_o  = diag_q;
  assign val_o       = val_q;
  assign byte_o      = byte_q;
  assign dir_o       = dir_q;

endmodule

@@ src/lcs_length_and_traceback.sv @@
// Longest common subsequence of two byte strings. Send the first string with
// tuser = 0, then the second with tuser = 1 and tlast on its final byte.
// First-string bytes are held one per cell of a row of MAX_LEN cells, and
// each second-string byte walks down that row one cell per cycle, so one
// table row is finished per byte. After the final byte the row drains, then
// each traceback step reads the cells' direction memories and then decides,
// for at most first length + second length steps; each result is then read
// from the answer buffer, registered to the output and held until
// m_axis_tready; an empty result is presented in the cycle right after the
// drain. No input transfer is taken from the final byte until the last result
// has gone. Bytes past MAX_LEN are dropped and flag truncated; an empty
// subsequence gives one result with tuser[0] = 0.
module lcs_length_and_traceback #(
  parameter int MAX_LEN  = 64,
  localparam int AW      = $clog2(MAX_LEN),
  localparam int VW      = $clog2(MAX_LEN + 1),
  localparam int DW      = ((VW + 8 + 7) / 8) * 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // symbol
  input  logic          s_axis_tuser,   // kind
  input  logic          s_axis_tlast,   // last
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [DW-1:0] m_axis_tdata,   // lcs_length, out_symbol, zero fill
  output logic [1:0]    m_axis_tuser,   // has_symbol, truncated
  output logic          m_axis_tlast    // end_of_run
);

  lcslt_pkg::state_e state_q, state_d;

  logic [VW-1:0] first_len_q, first_len_d;
  logic [VW-1:0] sec_len_q, sec_len_d;
  logic          ovf_q, ovf_d;
  logic          trunc_q, trunc_d;
  logic [VW-1:0] drain_q, drain_d;
  logic [VW-1:0] k_q, k_d;
  logic [VW-1:0] a_q, a_d;
  logic [VW-1:0] b_q, b_d;
  logic [VW-1:0] r_q, r_d;
  logic [VW-1:0] total_q, total_d;

  logic          inj_valid_q;
  logic          inj_first_q;
  logic [7:0]    inj_sym_q;
  logic [AW-1:0] inj_row_q;

  logic          in_xfer;
  logic          out_xfer;
  logic          push_second;
  logic          load_first;

  logic          lk_valid [MAX_LEN+1];
  logic          lk_first [MAX_LEN+1];
  logic [7:0]    lk_sym   [MAX_LEN+1];
  logic [AW-1:0] lk_row   [MAX_LEN+1];
  logic [VW-1:0] lk_up    [MAX_LEN+1];
  logic [VW-1:0] lk_diag  [MAX_LEN+1];
  logic [VW-1:0] val_w    [MAX_LEN];
  logic [7:0]    byte_w   [MAX_LEN];
  logic [1:0]    dir_w    [MAX_LEN];

  logic [VW-1:0] a_m1;
  logic [VW-1:0] fl_m1;
  logic [AW-1:0] tb_addr;
  logic [1:0]    dir_sel;

  logic [7:0]    ans_mem [MAX_LEN];
  logic [7:0]    ans_rd_q;
  logic          ans_we;

  logic          ov_valid_q, ov_valid_d;
  logic [VW-1:0] ov_len_q, ov_len_d;
  logic [7:0]    ov_sym_q, ov_sym_d;
  logic          ov_has_q, ov_has_d;
  logic          ov_end_q, ov_end_d;

  function automatic logic [AW-1:0] k_m1_idx(input logic [VW-1:0] k);
    logic [VW-1:0] km1;
    km1 = k - 1'b1;
    return km1[AW-1:0];
  endfunction

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  assign load_first  = in_xfer && (s_axis_tuser == lcslt_pkg::KIND_FIRST) &&
                       (sec_len_q == '0) && (first_len_q < VW'(MAX_LEN));
  assign push_second = in_xfer && (s_axis_tuser == lcslt_pkg::KIND_SECOND) &&
                       (sec_len_q < VW'(MAX_LEN));

  // Input to the head of the cell row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inj_valid_q <= 1'b0;
    end else begin
      inj_valid_q <= push_second;
    end
  end

  always_ff @(posedge clk_i) begin
    inj_first_q <= (sec_len_q == '0);
    inj_sym_q   <= s_axis_tdata;
    inj_row_q   <= sec_len_q[AW-1:0];
  end

  assign lk_valid[0] = inj_valid_q;
  assign lk_first[0] = inj_first_q;
  assign lk_sym[0]   = inj_sym_q;
  assign lk_row[0]   = inj_row_q;
  assign lk_up[0]    = '0;
  assign lk_diag[0]  = '0;

  assign a_m1    = a_q - 1'b1;
  assign fl_m1   = first_len_q - 1'b1;
  assign tb_addr = b_q[AW-1:0] - 1'b1;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    lcslt_cell #(
      .MAX_LEN (MAX_LEN),
      .AW      (AW),
      .VW      (VW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_en_i   (load_first && (first_len_q == VW'(i))),
      .load_sym_i  (s_axis_tdata),
      .in_valid_i  (lk_valid[i]),
      .in_first_i  (lk_first[i]),
      .in_sym_i    (lk_sym[i]),
      .in_row_i    (lk_row[i]),
      .in_up_i     (lk_up[i]),
      .in_diag_i   (lk_diag[i]),
      .out_valid_o (lk_valid[i+1]),
      .out_first_o (lk_first[i+1]),
      .out_sym_o   (lk_sym[i+1]),
      .out_row_o   (lk_row[i+1]),
      .out_up_o    (lk_up[i+1]),
      .out_diag_o  (lk_diag[i+1]),
      .val_o       (val_w[i]),
      .byte_o      (byte_w[i]),
      .rd_addr_i   (tb_addr),
      .dir_o       (dir_w[i])
    );
  end

  assign dir_sel = dir_w[a_m1[AW-1:0]];
  assign ans_we  = (state_q == lcslt_pkg::ST_TB_DEC) && dir_sel[lcslt_pkg::DIR_MATCH];

  // The traceback finds symbols last to first; the buffer puts them back in order.
  always_ff @(posedge clk_i) begin
    if (ans_we) begin
      ans_mem[k_m1_idx(k_q)] <= byte_w[a_m1[AW-1:0]];
    end
    ans_rd_q <= ans_mem[r_q[AW-1:0]];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lcslt_pkg::ST_LOAD: begin
        if (in_xfer && (s_axis_tuser == lcslt_pkg::KIND_SECOND) && s_axis_tlast) begin
          state_d = lcslt_pkg::ST_DRAIN;
        end
      end
      lcslt_pkg::ST_DRAIN: begin
        if (drain_q == '0) begin
          if (first_len_q == '0 || val_w[fl_m1[AW-1:0]] == '0) begin
            state_d = lcslt_pkg::ST_OUT_WAIT;
          end else begin
            state_d = lcslt_pkg::ST_TB_RD;
          end
        end
      end
      lcslt_pkg::ST_TB_RD: state_d = lcslt_pkg::ST_TB_DEC;
      lcslt_pkg::ST_TB_DEC: begin
        if (dir_sel[lcslt_pkg::DIR_MATCH] && k_q == VW'(1)) begin
          state_d = lcslt_pkg::ST_OUT_RD;
        end else begin
          state_d = lcslt_pkg::ST_TB_RD;
        end
      end
      lcslt_pkg::ST_OUT_RD:  state_d = lcslt_pkg::ST_OUT_SET;
      lcslt_pkg::ST_OUT_SET: state_d = lcslt_pkg::ST_OUT_WAIT;
      lcslt_pkg::ST_OUT_WAIT: begin
        if (out_xfer) begin
          state_d = ov_end_q ? lcslt_pkg::ST_LOAD : lcslt_pkg::ST_OUT_RD;
        end
      end
      default: state_d = lcslt_pkg::ST_LOAD;
    endcase
  end

  // Datapath updates per state.
  always_comb begin
    first_len_d = first_len_q;
    sec_len_d   = sec_len_q;
    ovf_d       = ovf_q;
    trunc_d     = trunc_q;
    drain_d     = drain_q;
    k_d         = k_q;
    a_d         = a_q;
    b_d         = b_q;
    r_d         = r_q;
    total_d     = total_q;
    ov_valid_d  = ov_valid_q;
    ov_len_d    = ov_len_q;
    ov_sym_d    = ov_sym_q;
    ov_has_d    = ov_has_q;
    ov_end_d    = ov_end_q;
    case (state_q)
      lcslt_pkg::ST_LOAD: begin
        if (load_first) begin
          first_len_d = first_len_q + 1'b1;
        end
        if (push_second) begin
          sec_len_d = sec_len_q + 1'b1;
        end
        if (in_xfer) begin
          if (s_axis_tuser == lcslt_pkg::KIND_FIRST) begin
            if (sec_len_q == '0 && first_len_q == VW'(MAX_LEN)) begin
              ovf_d = 1'b1;
            end
          end else if (sec_len_q == VW'(MAX_LEN)) begin
            ovf_d = 1'b1;
          end
        end
        drain_d = VW'(MAX_LEN);
      end
      lcslt_pkg::ST_DRAIN: begin
        drain_d = drain_q - 1'b1;
        if (drain_q == '0) begin
          total_d     = (first_len_q == '0) ? '0 : val_w[fl_m1[AW-1:0]];
          k_d         = total_d;
          a_d         = first_len_q;
          b_d         = sec_len_q;
          r_d         = '0;
          trunc_d     = ovf_q;
          first_len_d = '0;
          sec_len_d   = '0;
          ovf_d       = 1'b0;
          if (total_d == '0) begin
            ov_valid_d = 1'b1;
            ov_len_d   = '0;
            ov_sym_d   = '0;
            ov_has_d   = 1'b0;
            ov_end_d   = 1'b1;
          end
        end
      end
      lcslt_pkg::ST_TB_DEC: begin
        if (dir_sel[lcslt_pkg::DIR_MATCH]) begin
          k_d = k_q - 1'b1;
          a_d = a_q - 1'b1;
          b_d = b_q - 1'b1;
        end else if (dir_sel[lcslt_pkg::DIR_UP]) begin
          a_d = a_q - 1'b1;
        end else begin
          b_d = b_q - 1'b1;
        end
      end
      lcslt_pkg::ST_OUT_SET: begin
        ov_valid_d = 1'b1;
        ov_len_d   = total_q;
        ov_sym_d   = ans_rd_q;
        ov_has_d   = 1'b1;
        ov_end_d   = (r_q + 1'b1 == total_q);
      end
      lcslt_pkg::ST_OUT_WAIT: begin
        if (out_xfer) begin
          ov_valid_d = 1'b0;
          r_d        = r_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcslt_pkg::ST_LOAD;
      first_len_q <= '0;
      sec_len_q   <= '0;
      ovf_q       <= 1'b0;
      ov_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_len_q <= first_len_d;
      sec_len_q   <= sec_len_d;
      ovf_q       <= ovf_d;
      ov_valid_q  <= ov_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    trunc_q  <= trunc_d;
    drain_q  <= drain_d;
    k_q      <= k_d;
    a_q      <= a_d;
    b_q      <= b_d;
    r_q      <= r_d;
    total_q  <= total_d;
    ov_len_q <= ov_len_d;
    ov_sym_q <= ov_sym_d;
    ov_has_q <= ov_has_d;
    ov_end_q <= ov_end_d;
  end

  assign s_axis_tready = (state_q == lcslt_pkg::ST_LOAD);
  assign m_axis_tvalid = ov_valid_q;
  assign m_axis_tdata  = DW'({ov_sym_q, ov_len_q});
  assign m_axis_tuser  = {trunc_q, ov_has_q};
  assign m_axis_tlast  = ov_end_q;

  // The traceback never walks off the table while symbols remain.
  a_tb_inside : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcslt_pkg::ST_TB_DEC) |-> (a_q != '0 && b_q != '0 && k_q != '0))
    else $error("traceback left the table");

  // A result without a symbol is the single result of an empty run.
  a_empty_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && ov_len_q == '0))
    else $error("empty result malformed");

  // The final transfer of a run leaves the block cleared for the next one.
  a_run_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && m_axis_tlast) |=> (first_len_q == '0 && sec_len_q == '0 && !ovf_q &&
                                    state_q == lcslt_pkg::ST_LOAD))
    else $error("run not cleared");

  // Symbols are numbered within the run length.
  a_index_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (r_q < total_q))
    else $error("result index out of range");

endmodule

@@ dv/tb.sv @@
module tb;

  localparam int MaxLen = 64;
  localparam int DataW = 16;
  localparam int CycleLimit = 3000000;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata;  // symbol
  logic s_axis_tuser;        // kind
  logic s_axis_tlast;        // last
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [DataW-1:0] m_axis_tdata;  // lcs_length, out_symbol, zero fill
  logic [1:0] m_axis_tuser;        // has_symbol, truncated
  logic m_axis_tlast;              // end_of_run

  typedef struct packed {
    logic [6:0] length;
    logic [7:0] symbol;
    logic has_symbol;
    logic truncated;
    logic end_of_run;
  } lcs_result_t;

  lcs_result_t pending_results[$];
  logic [7:0] row_a[MaxLen];
  logic [7:0] row_b[MaxLen];
  logic [6:0] score[MaxLen+1][MaxLen+1];
  int len_a;
  int len_b;
  logic overflow;
  int fail_count;
  int send_idle_pct;
  int recv_idle_pct;
  longint cycles;

  lcs_length_and_traceback #(.MAX_LEN(MaxLen)) u_top (.*);

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver stall and checking of every result transfer.
  always @(posedge clk_i) begin
    lcs_result_t got;
    lcs_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[6:0], m_axis_tdata[14:7], m_axis_tuser[0], m_axis_tuser[1],
               m_axis_tlast};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            $display("%0t: expected %h actual %h", $time, want, got);
            fail_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Updates the subsequence state for one accepted byte, queueing results on a run end.
  task automatic predict_lcs(input logic kind, input logic [7:0] sym, input logic last);
    int a;
    int b;
    int k;
    int total;
    logic [7:0] answer[MaxLen];
    lcs_result_t res;
    if (kind == lcslt_pkg::KIND_FIRST) begin
      if (len_b == 0) begin
        if (len_a < MaxLen) begin
          row_a[len_a] = sym;
          len_a++;
        end else begin
          overflow = 1'b1;
        end
      end
      return;
    end
    if (len_b < MaxLen) begin
      row_b[len_b] = sym;
      len_b++;
      score[len_b][0] = '0;
      for (a = 1; a <= len_a; a++) begin
        score[0][a] = '0;
        if (row_a[a-1] == sym) score[len_b][a] = 7'(score[len_b-1][a-1] + 7'd1);
        else if (score[len_b][a-1] >= score[len_b-1][a]) score[len_b][a] = score[len_b][a-1];
        else score[len_b][a] = score[len_b-1][a];
      end
    end else begin
      overflow = 1'b1;
    end
    if (!last) return;
    total = (len_a == 0 || len_b == 0) ? 0 : score[len_b][len_a];
    k = total;
    a = len_a;
    b = len_b;
    while (k > 0 && a > 0 && b > 0) begin
      if (row_a[a-1] == row_b[b-1]) begin
        answer[k-1] = row_a[a-1];
        k--;
        a--;
        b--;
      end else if ((a > 1 ? score[b][a-1] : 7'd0) >= (b > 1 ? score[b-1][a] : 7'd0)) begin
        a--;
      end else begin
        b--;
      end
    end
    if (total == 0) begin
      res = '{length: 0, symbol: 0, has_symbol: 0, truncated: overflow, end_of_run: 1};
      pending_results.push_back(res);
    end
    for (int r = 0; r < total; r++) begin
      res = '{length: total[6:0], symbol: answer[r], has_symbol: 1, truncated: overflow,
              end_of_run: (r + 1 == total)};
      pending_results.push_back(res);
    end
    len_a = 0;
    len_b = 0;
    overflow = 1'b0;
  endtask

  task automatic send_byte(input logic kind, input logic [7:0] sym, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= sym;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_lcs(kind, sym, last);
  endtask

  // Sends a run; an alphabet mask keeps matches frequent for short alphabets.
  task automatic send_run(input int n_a, input int n_b, input logic [7:0] mask,
                          input bit late_first);
    for (int i = 0; i < n_a; i++)
      send_byte(lcslt_pkg::KIND_FIRST, 8'($urandom) & mask, 1'($urandom_range(1)));
    for (int i = 0; i < n_b; i++) begin
      if (late_first && i == 1)
        send_byte(lcslt_pkg::KIND_FIRST, 8'($urandom), 1'($urandom_range(1)));
      send_byte(lcslt_pkg::KIND_SECOND, 8'($urandom) & mask, i == n_b - 1);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_byte(lcslt_pkg::KIND_FIRST, 8'h00, 1'b0);
    send_byte(lcslt_pkg::KIND_FIRST, 8'hFF, 1'b1);
    send_byte(lcslt_pkg::KIND_SECOND, 8'hFF, 1'b0);
    send_byte(lcslt_pkg::KIND_SECOND, 8'h00, 1'b1);
    // An empty first string, or two strings with no common byte, give the empty result.
    send_byte(lcslt_pkg::KIND_SECOND, 8'hA5, 1'b1);
    send_byte(lcslt_pkg::KIND_FIRST, 8'h5A, 1'b1);
    send_byte(lcslt_pkg::KIND_SECOND, 8'hA5, 1'b1);
    // A run that likely ties in the traceback and carries a late first-string byte.
    send_run(2, 2, 8'h01, 1'b1);
    send_run(3, 3, 8'h00, 1'b0);
    wait_drained();
  endtask

  task automatic test_overflow();
    send_run(MaxLen + 2, MaxLen + 2, 8'h03, 1'b0);
    send_run(MaxLen, MaxLen, 8'h00, 1'b0);
    send_run(3, MaxLen + 1, 8'h01, 1'b0);
    wait_drained();
  endtask

  task automatic test_random(input int n_items);
    int sent;
    int n_a;
    int n_b;
    sent = 0;
    while (sent < n_items) begin
      n_a = ($urandom_range(9) == 0) ? $urandom_range(MaxLen) : $urandom_range(8);
      n_b = ($urandom_range(9) == 0) ? $urandom_range(1, MaxLen) : $urandom_range(1, 8);
      send_run(n_a, n_b, $urandom_range(3) == 0 ? 8'hFF : 8'h07, $urandom_range(5) == 0);
      sent += n_a + n_b;
    end
    wait_drained();
  endtask

  initial begin
    fail_count = 0;
    cycles = 0;
    len_a = 0;
    len_b = 0;
    overflow = 1'b0;
    send_idle_pct = 26;
    recv_idle_pct = 54;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = lcslt_pkg::KIND_FIRST;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random(50);
    send_idle_pct = 54;
    recv_idle_pct = 26;
    test_random(50);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(50);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
